[rtl/edu_pkg.sv]
package edu_pkg;

  localparam int unsigned AccW  = 42;
  localparam int unsigned RootW = 21;
  localparam int unsigned RemW  = RootW + 3;
  localparam int unsigned IterW = $clog2(RootW);

  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  typedef struct packed {
    logic [AccW-1:0] sum;
    logic            ovf;
  } edu_sum_t;

  typedef struct packed {
    logic     valid;
    edu_sum_t data;
  } edu_push_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CALC,
    B_DONE
  } edu_state_e;

endpackage

[rtl/edu_front.sv]
module edu_front import edu_pkg::*; #(
  parameter int unsigned MAX_LEN      = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] elem_a_i,
  input  logic [15:0] elem_b_i,
  input  logic        last_i,
  input  logic        full_i,
  output edu_push_t   push_o
);

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);
  localparam int unsigned SqW  = 2 * SAMPLE_WIDTH + 1;

  logic signed [SAMPLE_WIDTH:0]     a_ext;
  logic signed [SAMPLE_WIDTH:0]     b_ext;
  logic signed [SAMPLE_WIDTH:0]     diff;
  logic signed [2*SAMPLE_WIDTH:0]   prod;

  logic            advance;
  logic            accept;
  logic            beyond;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic           s1_valid_q;
  logic [SqW-1:0] s1_sq_q;
  logic           s1_last_q;
  logic           s1_over_q;

  logic [AccW-1:0] acc_q, acc_d;
  logic            sat_q, sat_d;
  logic [AccW:0]   sum_wide;
  logic [AccW-1:0] acc_new;
  logic            sat_new;

  assign a_ext = {elem_a_i[SAMPLE_WIDTH-1], elem_a_i[SAMPLE_WIDTH-1:0]};
  assign b_ext = {elem_b_i[SAMPLE_WIDTH-1], elem_b_i[SAMPLE_WIDTH-1:0]};
  assign diff  = a_ext - b_ext;
  assign prod  = diff * diff;

  assign advance    = !(s1_valid_q && s1_last_q && full_i);
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;
  assign beyond     = (cnt_q >= CntW'(MAX_LEN));

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (last_i) begin
        cnt_d = '0;
      end else if (!beyond) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (advance) begin
        s1_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sq_q   <= prod[SqW-1:0];
      s1_last_q <= last_i;
      s1_over_q <= beyond;
    end
  end

  assign sum_wide = {1'b0, acc_q} + {{(AccW + 1 - SqW){1'b0}}, s1_sq_q};

  always_comb begin
    if (s1_over_q) begin
      acc_new = AccMax;
      sat_new = 1'b1;
    end else begin
      acc_new = sum_wide[AccW] ? AccMax : sum_wide[AccW-1:0];
      sat_new = sat_q;
    end
  end

  always_comb begin
    acc_d       = acc_q;
    sat_d       = sat_q;
    push_o      = '0;
    push_o.data = '{sum: acc_new, ovf: sat_new};
    if (s1_valid_q && advance) begin
      if (s1_last_q) begin
        push_o.valid = 1'b1;
        acc_d        = '0;
        sat_d        = 1'b0;
      end else begin
        acc_d = acc_new;
        sat_d = sat_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      sat_q <= sat_d;
    end
  end

endmodule

[rtl/edu_fifo.sv]
module edu_fifo import edu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  edu_push_t push_i,
  output logic      full_o,
  output logic      empty_o,
  input  logic      pop_i,
  output edu_sum_t  data_o
);

  edu_sum_t   mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i.valid && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i.valid) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

[rtl/edu_sqrt.sv]
module edu_sqrt import edu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  edu_sum_t         data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [RootW-1:0] distance_o,
  output logic [AccW-1:0]  squared_sum_o,
  output logic             overflow_o
);

  edu_state_e state_q, state_d;

  logic             load;
  logic             step;
  logic             emit;
  logic             last_step;

  logic [AccW-1:0]  rad_q;
  logic [AccW-1:0]  sum_q;
  logic             ovf_q;
  logic [RootW-1:0] root_q;
  logic [RemW-1:0]  rem_q;
  logic [IterW-1:0] iter_q;

  logic [RemW-1:0]  rem_shift;
  logic [RemW-1:0]  trial;
  logic             take;

  logic             out_valid_q;
  logic [RootW-1:0] dist_out_q;
  logic [AccW-1:0]  sum_out_q;
  logic             ovf_out_q;

  assign last_step = (iter_q == '0);
  assign rem_shift = {rem_q[RemW-3:0], rad_q[AccW-1:AccW-2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign take      = (rem_shift >= trial);

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    step    = 1'b0;
    emit    = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          load    = 1'b1;
          state_d = B_CALC;
        end
      end
      B_CALC: begin
        step = 1'b1;
        if (last_step) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          emit    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rad_q  <= data_i.sum;
      sum_q  <= data_i.sum;
      ovf_q  <= data_i.ovf;
      root_q <= '0;
      rem_q  <= '0;
      iter_q <= IterW'(RootW - 1);
    end else if (step) begin
      rad_q  <= {rad_q[AccW-3:0], 2'b00};
      iter_q <= iter_q - IterW'(1);
      if (take) begin
        rem_q  <= rem_shift - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_shift;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (emit) begin
      dist_out_q <= root_q;
      sum_out_q  <= sum_q;
      ovf_out_q  <= ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_o    = dist_out_q;
  assign squared_sum_o = sum_out_q;
  assign overflow_o    = ovf_out_q;

endmodule

[rtl/euclidean_distance_unit.sv]
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    elem_a_i, elem_b_i, last_i
// out      output     out_valid_o / out_stall_i  distance_o, squared_sum_o, overflow_o
//
// The input side takes one element pair per cycle while in_stall_o is low, squares
// the difference into a pipeline register, then adds it into the accumulator.
// The square root loads a sum from the queue, works out the root one bit per step and
// then hands it to the output register; it takes no new sum until that hand-off.
// A two-entry queue holds finished sums; the input stalls only when a finished sum waits on a full queue.
// Reset clears the accumulator, the element count, the queue and the output valid.
module euclidean_distance_unit import edu_pkg::*; #(
  parameter int unsigned MAX_LEN      = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [15:0]       elem_a_i,
  input  logic [15:0]       elem_b_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [RootW-1:0]  distance_o,
  output logic [AccW-1:0]   squared_sum_o,
  output logic              overflow_o
);

  edu_push_t push;
  logic      full;
  logic      empty;
  logic      pop;
  edu_sum_t  head;

  edu_front #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .elem_a_i   (elem_a_i),
    .elem_b_i   (elem_b_i),
    .last_i     (last_i),
    .full_i     (full),
    .push_o     (push)
  );

  edu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (head)
  );

  edu_sqrt u_sqrt (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .data_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .distance_o    (distance_o),
    .squared_sum_o (squared_sum_o),
    .overflow_o    (overflow_o)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import edu_pkg::*;

  localparam int unsigned MaxLen = 1024;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [RootW-1:0] root;
    logic [AccW-1:0]  sum;
    logic             ovf;
  } dist_result_t;

  typedef struct packed {
    logic [15:0]      a;
    logic [15:0]      b;
    logic             last;
    logic             typed;
    logic [RootW-1:0] root;
    logic [AccW-1:0]  sum;
    logic             ovf;
  } pair_row_t;

  typedef enum int {
    SMP_FULL,
    SMP_EDGE,
    SMP_SMALL
  } sample_mode_e;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [15:0]       elem_a_i = '0;
  logic [15:0]       elem_b_i = '0;
  logic              last_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [RootW-1:0]  distance_o;
  logic [AccW-1:0]   squared_sum_o;
  logic              overflow_o;

  euclidean_distance_unit #(
    .MAX_LEN     (MaxLen),
    .SAMPLE_WIDTH(16)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .elem_a_i     (elem_a_i),
    .elem_b_i     (elem_b_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .distance_o   (distance_o),
    .squared_sum_o(squared_sum_o),
    .overflow_o   (overflow_o)
  );

  pair_row_t dir_rows [0:21] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 21'd0, 42'd0, 1'b0},
    '{16'h7fff, 16'h8000, 1'b1, 1'b1, 21'd65535, 42'd4294836225, 1'b0},
    '{16'h8000, 16'h7fff, 1'b1, 1'b1, 21'd65535, 42'd4294836225, 1'b0},
    '{16'h8000, 16'h8000, 1'b1, 1'b1, 21'd0, 42'd0, 1'b0},
    '{16'h7fff, 16'h7fff, 1'b1, 1'b1, 21'd0, 42'd0, 1'b0},
    '{16'h0003, 16'hffff, 1'b1, 1'b1, 21'd4, 42'd16, 1'b0},
    '{16'h0000, 16'h0003, 1'b0, 1'b0, 21'd0, 42'd0, 1'b0},
    '{16'h0000, 16'hfffc, 1'b1, 1'b1, 21'd5, 42'd25, 1'b0},
    '{16'h0001, 16'h0000, 1'b0, 1'b0, 21'd0, 42'd0, 1'b0},
    '{16'h0000, 16'h0001, 1'b1, 1'b1, 21'd1, 42'd2, 1'b0},
    '{16'h7fff, 16'h8000, 1'b0, 1'b0, 21'd0, 42'd0, 1'b0},
    '{16'h8000, 16'h7fff, 1'b0, 1'b0, 21'd0, 42'd0, 1'b0},
    '{16'h7fff, 16'h8000, 1'b1, 1'b0, 21'd0, 42'd0, 1'b0},
    '{16'h5555, 16'haaaa, 1'b1, 1'b0, 21'd0, 42'd0, 1'b0},
    '{16'haaaa, 16'h5555, 1'b0, 1'b0, 21'd0, 42'd0, 1'b0},
    '{16'h0001, 16'hfffe, 1'b0, 1'b0, 21'd0, 42'd0, 1'b0},
    '{16'h1234, 16'hedcb, 1'b1, 1'b0, 21'd0, 42'd0, 1'b0},
    '{16'hffff, 16'h0000, 1'b1, 1'b1, 21'd1, 42'd1, 1'b0},
    '{16'h0000, 16'h8000, 1'b1, 1'b1, 21'd32768, 42'd1073741824, 1'b0},
    '{16'h0006, 16'h0002, 1'b0, 1'b0, 21'd0, 42'd0, 1'b0},
    '{16'h0002, 16'hffff, 1'b0, 1'b0, 21'd0, 42'd0, 1'b0},
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 21'd5, 42'd25, 1'b0}
  };

  logic [AccW-1:0] acc_sum = '0;
  int unsigned     pair_cnt = 0;
  bit              acc_sat = 1'b0;

  dist_result_t    sums_due[$];
  bit              pend_typed = 1'b0;
  dist_result_t    pend_exp = '0;

  int unsigned     in_idle_pct = 6;
  int unsigned     out_idle_pct = 55;
  int unsigned     cycles = 0;
  int unsigned     errors = 0;
  int unsigned     pairs_sent = 0;
  int unsigned     dists_checked = 0;
  int unsigned     sat_seen = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d distances outstanding.", cycles,
               sums_due.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [RootW-1:0] floor_root(logic [AccW-1:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int k = RootW - 1; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= {22'd0, v}) r = t;
    end
    return r[RootW-1:0];
  endfunction

  function automatic void accumulate_pair(input logic [15:0] a, input logic [15:0] b,
                                          input logic l, output bit done,
                                          output dist_result_t res);
    longint      d;
    logic [63:0] sq;
    logic [63:0] tot;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d < 0) d = -d;
    sq = d * d;
    if (pair_cnt >= MaxLen) begin
      acc_sat = 1'b1;
      acc_sum = AccMax;
    end else begin
      tot = {22'd0, acc_sum} + sq;
      acc_sum = (tot > {22'd0, AccMax}) ? AccMax : tot[AccW-1:0];
      pair_cnt++;
    end
    done = l;
    res = '0;
    if (l) begin
      res.root = floor_root(acc_sum);
      res.sum = acc_sum;
      res.ovf = acc_sat;
      acc_sum = '0;
      pair_cnt = 0;
      acc_sat = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    bit           done;
    dist_result_t res;
    dist_result_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      accumulate_pair(elem_a_i, elem_b_i, last_i, done, res);
      if (done) begin
        if (pend_typed) res = pend_exp;
        sums_due.push_back(res);
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sums_due.size() == 0) begin
        $display("%0t: result transfer with none expected: distance %0d sum %0d ovf %0b",
                 $time, distance_o, squared_sum_o, overflow_o);
        errors++;
      end else begin
        want = sums_due.pop_front();
        dists_checked++;
        if (overflow_o) sat_seen++;
        if (distance_o !== want.root) begin
          $display("%0t: distance expected %0d, actual %0d", $time, want.root, distance_o);
          errors++;
        end
        if (squared_sum_o !== want.sum) begin
          $display("%0t: squared_sum expected %0d, actual %0d", $time, want.sum,
                   squared_sum_o);
          errors++;
        end
        if (overflow_o !== want.ovf) begin
          $display("%0t: overflow expected %0b, actual %0b", $time, want.ovf, overflow_o);
          errors++;
        end
      end
    end
  end

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic l,
                           input bit typed, input dist_result_t exp_res);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pend_typed = typed;
    pend_exp = exp_res;
    in_valid_i <= 1'b1;
    elem_a_i <= a;
    elem_b_i <= b;
    last_i <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pairs_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample(sample_mode_e mode);
    logic [15:0] v;
    case (mode)
      SMP_EDGE: begin
        case ($urandom_range(0, 5))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h0000;
          3: v = 16'hffff;
          4: v = 16'h0001;
          default: v = 16'($urandom);
        endcase
      end
      SMP_SMALL: v = 16'($signed($urandom_range(0, 16)) - 8);
      default: v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  task automatic send_vector(input int unsigned len, input sample_mode_e mode);
    for (int unsigned i = 0; i < len; i++) begin
      send_pair(pick_sample(mode), pick_sample(mode), i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic send_random_vectors(input int unsigned count);
    int unsigned  stop_at;
    int unsigned  len;
    sample_mode_e mode;
    stop_at = pairs_sent + count;
    while (pairs_sent < stop_at) begin
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 20);
      mode = sample_mode_e'($urandom_range(0, 2));
      send_vector(len, mode);
    end
  endtask

  task automatic send_max_vector(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_pair(16'h7fff, 16'h8000, i == len - 1, 1'b0, '0);
    end
  endtask

  initial begin
    dist_result_t exp_res;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    in_idle_pct = 6;
    out_idle_pct = 55;
    foreach (dir_rows[i]) begin
      exp_res.root = dir_rows[i].root;
      exp_res.sum = dir_rows[i].sum;
      exp_res.ovf = dir_rows[i].ovf;
      send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
                exp_res);
    end
    send_random_vectors(130);

    in_idle_pct = 55;
    out_idle_pct = 6;
    send_random_vectors(130);
    send_max_vector(MaxLen + 1);

    in_idle_pct = 0;
    out_idle_pct = 0;
    send_random_vectors(120);

    in_valid_i <= 1'b0;
    last_i <= 1'b0;
    while (sums_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Streamed %0d element pairs and checked %0d distances, %0d of them saturated.",
             pairs_sent, dists_checked, sat_seen);
    $display("Mismatches found: %0d.", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
